/* src/cdl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_pkg
// Types, codes and defaults shared by the cursor linked list block.
// ----------------------------------------------------------------------------
package cdl_pkg;

    localparam int DEF_POOL_NODES = 256;
    localparam int DEF_COORD_BITS = 8;
    localparam int FUNC_W         = 4;

    typedef enum logic [FUNC_W-1:0] {
        F_CLEAR    = 4'd0,
        F_HEAD     = 4'd1,
        F_END      = 4'd2,
        F_NEXT     = 4'd3,
        F_PREV     = 4'd4,
        F_READ     = 4'd5,
        F_REMOVE   = 4'd6,
        F_INS_LEFT = 4'd7,
        F_INS_RGHT = 4'd8,
        F_APP_HEAD = 4'd9,
        F_APP_END  = 4'd10,
        F_SEARCH   = 4'd11
    } t_func;

    // datapath step commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DEC,
        OP_STEP,
        OP_RM_LNK,
        OP_RM_FREE,
        OP_IN_CHK,
        OP_IN_RD,
        OP_IN_SET,
        OP_IN_LNK,
        OP_SR_RD,
        OP_SR_CMP,
        OP_OUT_RD,
        OP_OUT_SET
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              cur_out;
        logic              ins_skip;
        logic              alloc_fail;
        logic              walk_end;
        logic              match;
    } t_stat;

endpackage

/* src/cdl_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_if
// Request and result channels of the cursor linked list block.
// ----------------------------------------------------------------------------
interface cdl_in_if #(
    parameter int COORD_BITS = cdl_pkg::DEF_COORD_BITS
);
    logic                      valid;
    logic                      ready;
    logic [cdl_pkg::FUNC_W-1:0] func;
    logic [COORD_BITS-1:0]     pos_line;
    logic [COORD_BITS-1:0]     pos_col;

    modport source (output valid, output func, output pos_line, output pos_col,
                    input ready);
    modport sink   (input valid, input func, input pos_line, input pos_col,
                    output ready);
endinterface

interface cdl_out_if #(
    parameter int COORD_BITS = cdl_pkg::DEF_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] read_line;
    logic [COORD_BITS-1:0] read_col;
    logic                  cursor_out;
    logic                  list_empty;
    logic                  found;
    logic                  pool_full;

    modport source (output valid, output read_line, output read_col,
                    output cursor_out, output list_empty, output found,
                    output pool_full, input ready);
    modport sink   (input valid, input read_line, input read_col,
                    input cursor_out, input list_empty, input found,
                    input pool_full, output ready);
endinterface

/* src/cursor_doubly_linked_list_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_top
// Doubly linked list of positions in a node pool, with a cursor.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. After the request
// is loaded and decoded, next and prev step the cursor, remove unlinks the
// node and then frees it, and an insert checks, reads, sets and links. Next,
// prev and remove with the cursor out skip these steps, and an insert that
// is ignored or dropped for a full pool stops after its check. A search reads
// and compares each element visited until a match or the end of the list,
// since each element costs one read of the data and link memories and one
// compare. Each request ends by reading the node data and setting the result.
// The link and data memories have one write and one registered read port
// each, so the pointer updates of an insert or remove are spread over separate
// steps. The next request is accepted only once the result is taken and the
// block is idle again. Free nodes come first from a chain of removed nodes,
// then a fill counter, so no clearing pass is needed after reset; clear is one step.
module cursor_doubly_linked_list_top #(
    parameter int POOL_NODES = cdl_pkg::DEF_POOL_NODES,
    parameter int COORD_BITS = cdl_pkg::DEF_COORD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdl_in_if.sink    i_item,
    cdl_out_if.source o_res
);
    import cdl_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready, out_valid;

    cdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .i_out_ready(o_res.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cdl_datapath #(
        .POOL_NODES(POOL_NODES),
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_func      (i_item.func),
        .i_line      (i_item.pos_line),
        .i_col       (i_item.pos_col),
        .o_line      (o_res.read_line),
        .o_col       (o_res.read_col),
        .o_cursor_out(o_res.cursor_out),
        .o_list_empty(o_res.list_empty),
        .o_found     (o_res.found),
        .o_pool_full (o_res.pool_full)
    );

    assign i_item.ready = in_ready;
    assign o_res.valid  = out_valid;
endmodule

/* src/cdl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

/* src/cdl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_ctrl
// Sequencer: steps one request through its memory cycles.
// ----------------------------------------------------------------------------
module cdl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  cdl_pkg::t_stat i_stat,
    output cdl_pkg::t_cmd  o_cmd
);
    import cdl_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_DEC      = 14'b00000000000010,
        S_STEP     = 14'b00000000000100,
        S_RM_LNK   = 14'b00000000001000,
        S_RM_FREE  = 14'b00000000010000,
        S_IN_CHK   = 14'b00000000100000,
        S_IN_RD    = 14'b00000001000000,
        S_IN_SET   = 14'b00000010000000,
        S_IN_LNK   = 14'b00000100000000,
        S_SR_RD    = 14'b00001000000000,
        S_SR_CMP   = 14'b00010000000000,
        S_OUT_RD   = 14'b00100000000000,
        S_OUT_SET  = 14'b01000000000000,
        S_OUT_WAIT = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.op = OP_DEC;
                case (i_stat.func)
                    F_NEXT, F_PREV: n_state = i_stat.cur_out ? S_OUT_RD : S_STEP;
                    F_REMOVE:       n_state = i_stat.cur_out ? S_OUT_RD : S_RM_LNK;
                    F_INS_LEFT, F_INS_RGHT, F_APP_HEAD, F_APP_END: n_state = S_IN_CHK;
                    F_SEARCH:       n_state = S_SR_RD;
                    default:        n_state = S_OUT_RD;
                endcase
            end
            S_STEP: begin
                o_cmd.op = OP_STEP;
                n_state  = S_OUT_RD;
            end
            S_RM_LNK: begin
                o_cmd.op = OP_RM_LNK;
                n_state  = S_RM_FREE;
            end
            S_RM_FREE: begin
                o_cmd.op = OP_RM_FREE;
                n_state  = S_OUT_RD;
            end
            S_IN_CHK: begin
                o_cmd.op = OP_IN_CHK;
                n_state  = (i_stat.ins_skip || i_stat.alloc_fail) ? S_OUT_RD : S_IN_RD;
            end
            S_IN_RD: begin
                o_cmd.op = OP_IN_RD;
                n_state  = S_IN_SET;
            end
            S_IN_SET: begin
                o_cmd.op = OP_IN_SET;
                n_state  = S_IN_LNK;
            end
            S_IN_LNK: begin
                o_cmd.op = OP_IN_LNK;
                n_state  = S_OUT_RD;
            end
            S_SR_RD: begin
                o_cmd.op = OP_SR_RD;
                n_state  = i_stat.walk_end ? S_OUT_RD : S_SR_CMP;
            end
            S_SR_CMP: begin
                o_cmd.op = OP_SR_CMP;
                n_state  = i_stat.match ? S_OUT_RD : S_SR_RD;
            end
            S_OUT_RD: begin
                o_cmd.op = OP_OUT_RD;
                n_state  = S_OUT_SET;
            end
            S_OUT_SET: begin
                o_cmd.op = OP_OUT_SET;
                n_state  = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT_WAIT);
endmodule

/* src/cdl_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_datapath
// Node pool memories, list pointers, cursor and result register.
// ----------------------------------------------------------------------------
module cdl_datapath #(
    parameter int POOL_NODES = cdl_pkg::DEF_POOL_NODES,
    parameter int COORD_BITS = cdl_pkg::DEF_COORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cdl_pkg::t_cmd              i_cmd,
    output cdl_pkg::t_stat             o_stat,
    input  logic [cdl_pkg::FUNC_W-1:0] i_func,
    input  logic [COORD_BITS-1:0]      i_line,
    input  logic [COORD_BITS-1:0]      i_col,
    output logic [COORD_BITS-1:0]      o_line,
    output logic [COORD_BITS-1:0]      o_col,
    output logic                       o_cursor_out,
    output logic                       o_list_empty,
    output logic                       o_found,
    output logic                       o_pool_full
);
    import cdl_pkg::*;

    localparam int IW = $clog2(POOL_NODES + 1);
    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int DW = 2 * COORD_BITS;
    localparam logic [IW-1:0] SENT = IW'(POOL_NODES);

    logic [IW-1:0]         r_head, n_head, r_tail, n_tail, r_fh, n_fh;
    logic [IW-1:0]         r_fill, n_fill, r_cur, n_cur, r_walk, n_walk;
    logic [IW-1:0]         r_t, n_t, r_nb, n_nb;
    logic                  r_from_free, n_from_free;
    logic [FUNC_W-1:0]     r_func, n_func;
    logic [COORD_BITS-1:0] r_line, n_line, r_col, n_col;
    logic                  r_found, n_found, r_full, n_full;
    logic [COORD_BITS-1:0] r_o_line, n_o_line, r_o_col, n_o_col;
    logic                  r_o_out, n_o_out, r_o_empty, n_o_empty;
    logic                  r_o_found, n_o_found, r_o_full, n_o_full;

    logic          nx_we, nx_re, pv_we, pv_re, dt_we, dt_re;
    logic [AW-1:0] nx_wa, nx_ra, pv_wa, pv_ra, dt_wa, dt_ra;
    logic [IW-1:0] nx_wd, pv_wd, nx_q, pv_q;
    logic [DW-1:0] dt_wd, dt_q;

    logic cur_out, empty, left, ins_skip, alloc_fail;

    cdl_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_re(nx_re), .i_raddr(nx_ra), .o_rdata(nx_q)
    );
    cdl_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_re(pv_re), .i_raddr(pv_ra), .o_rdata(pv_q)
    );
    cdl_ram #(.WIDTH(DW), .DEPTH(POOL_NODES)) u_data (
        .i_clk(i_clk), .i_we(dt_we), .i_waddr(dt_wa), .i_wdata(dt_wd),
        .i_re(dt_re), .i_raddr(dt_ra), .o_rdata(dt_q)
    );

    assign cur_out    = (r_cur == SENT);
    assign empty      = (r_head == SENT);
    assign left       = (r_func == F_INS_LEFT) || (r_func == F_APP_HEAD);
    assign ins_skip   = !empty && cur_out;
    // free chain empty and every fresh node handed out
    assign alloc_fail = (r_fh == SENT) && (r_fill == SENT);

    assign o_stat.func       = r_func;
    assign o_stat.cur_out    = cur_out;
    assign o_stat.ins_skip   = ins_skip;
    assign o_stat.alloc_fail = alloc_fail;
    assign o_stat.walk_end   = (r_walk == SENT);
    assign o_stat.match      = (dt_q == {r_line, r_col});

    always_comb begin
        n_head = r_head;  n_tail = r_tail;  n_fh = r_fh;  n_fill = r_fill;
        n_cur = r_cur;    n_walk = r_walk;  n_t = r_t;    n_nb = r_nb;
        n_from_free = r_from_free;
        n_func = r_func;  n_line = r_line;  n_col = r_col;
        n_found = r_found; n_full = r_full;
        n_o_line = r_o_line; n_o_col = r_o_col; n_o_out = r_o_out;
        n_o_empty = r_o_empty; n_o_found = r_o_found; n_o_full = r_o_full;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_re = 1'b0; nx_ra = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_re = 1'b0; pv_ra = '0;
        dt_we = 1'b0; dt_wa = '0; dt_wd = '0; dt_re = 1'b0; dt_ra = '0;

        unique case (i_cmd.op)
            OP_NONE: ;
            OP_LOAD: begin
                n_func  = i_func;
                n_line  = i_line;
                n_col   = i_col;
                n_found = 1'b0;
                n_full  = 1'b0;
            end
            OP_DEC: begin
                // links of the node under the cursor, used by step and remove
                nx_re = 1'b1;
                nx_ra = r_cur[AW-1:0];
                pv_re = 1'b1;
                pv_ra = r_cur[AW-1:0];
                case (r_func)
                    F_CLEAR: begin
                        n_head = SENT;
                        n_tail = SENT;
                        n_fh   = SENT;
                        n_fill = '0;
                        n_cur  = SENT;
                    end
                    F_HEAD, F_APP_HEAD: n_cur = r_head;
                    F_END, F_APP_END:   n_cur = r_tail;
                    F_SEARCH:           n_walk = r_head;
                    default: ;
                endcase
            end
            OP_STEP: begin
                n_cur = (r_func == F_NEXT) ? nx_q : pv_q;
            end
            OP_RM_LNK: begin
                if (nx_q == SENT) begin
                    n_tail = pv_q;
                end else begin
                    pv_we = 1'b1;
                    pv_wa = nx_q[AW-1:0];
                    pv_wd = pv_q;
                end
                if (pv_q == SENT) begin
                    n_head = nx_q;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = pv_q[AW-1:0];
                    nx_wd = nx_q;
                end
                n_nb = pv_q;
            end
            OP_RM_FREE: begin
                nx_we = 1'b1;
                nx_wa = r_cur[AW-1:0];
                nx_wd = r_fh;
                n_fh  = r_cur;
                n_cur = r_nb;
            end
            OP_IN_CHK: begin
                pv_re = 1'b1;
                pv_ra = r_cur[AW-1:0];
                if (!ins_skip) begin
                    if (r_fh != SENT) begin
                        n_t         = r_fh;
                        n_from_free = 1'b1;
                        nx_re       = 1'b1;
                        nx_ra       = r_fh[AW-1:0];
                    end else if (r_fill != SENT) begin
                        n_t         = r_fill;
                        n_from_free = 1'b0;
                        n_fill      = r_fill + 1'b1;
                    end else begin
                        n_full = 1'b1;
                    end
                end
            end
            OP_IN_RD: begin
                if (r_from_free) begin
                    n_fh = nx_q;
                end
                n_nb  = pv_q;
                dt_we = 1'b1;
                dt_wa = r_t[AW-1:0];
                dt_wd = {r_line, r_col};
                nx_re = 1'b1;
                nx_ra = r_cur[AW-1:0];
            end
            OP_IN_SET: begin
                if (!left) begin
                    n_nb = nx_q;
                end
                nx_we = 1'b1;
                nx_wa = r_t[AW-1:0];
                pv_we = 1'b1;
                pv_wa = r_t[AW-1:0];
                if (empty) begin
                    nx_wd = SENT;
                    pv_wd = SENT;
                end else if (left) begin
                    nx_wd = r_cur;
                    pv_wd = r_nb;
                end else begin
                    nx_wd = nx_q;
                    pv_wd = r_cur;
                end
            end
            OP_IN_LNK: begin
                if (empty) begin
                    n_head = r_t;
                    n_tail = r_t;
                end else if (left) begin
                    if (r_nb == SENT) begin
                        n_head = r_t;
                    end else begin
                        nx_we = 1'b1;
                        nx_wa = r_nb[AW-1:0];
                        nx_wd = r_t;
                    end
                    pv_we = 1'b1;
                    pv_wa = r_cur[AW-1:0];
                    pv_wd = r_t;
                end else begin
                    if (r_nb == SENT) begin
                        n_tail = r_t;
                    end else begin
                        pv_we = 1'b1;
                        pv_wa = r_nb[AW-1:0];
                        pv_wd = r_t;
                    end
                    nx_we = 1'b1;
                    nx_wa = r_cur[AW-1:0];
                    nx_wd = r_t;
                end
                n_cur = r_t;
            end
            OP_SR_RD: begin
                if (r_walk == SENT) begin
                    n_cur = SENT;
                end else begin
                    dt_re = 1'b1;
                    dt_ra = r_walk[AW-1:0];
                    nx_re = 1'b1;
                    nx_ra = r_walk[AW-1:0];
                end
            end
            OP_SR_CMP: begin
                if (dt_q == {r_line, r_col}) begin
                    n_found = 1'b1;
                    n_cur   = r_walk;
                end else begin
                    n_walk = nx_q;
                end
            end
            OP_OUT_RD: begin
                dt_re = !cur_out;
                dt_ra = r_cur[AW-1:0];
            end
            OP_OUT_SET: begin
                n_o_line  = cur_out ? '0 : dt_q[DW-1:COORD_BITS];
                n_o_col   = cur_out ? '0 : dt_q[COORD_BITS-1:0];
                n_o_out   = cur_out;
                n_o_empty = empty;
                n_o_found = r_found;
                n_o_full  = r_full;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= SENT;
            r_tail <= SENT;
            r_fh   <= SENT;
            r_fill <= '0;
            r_cur  <= SENT;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fh   <= n_fh;
            r_fill <= n_fill;
            r_cur  <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk      <= n_walk;
        r_t         <= n_t;
        r_nb        <= n_nb;
        r_from_free <= n_from_free;
        r_func      <= n_func;
        r_line      <= n_line;
        r_col       <= n_col;
        r_found     <= n_found;
        r_full      <= n_full;
        r_o_line    <= n_o_line;
        r_o_col     <= n_o_col;
        r_o_out     <= n_o_out;
        r_o_empty   <= n_o_empty;
        r_o_found   <= n_o_found;
        r_o_full    <= n_o_full;
    end

    assign o_line       = r_o_line;
    assign o_col        = r_o_col;
    assign o_cursor_out = r_o_out;
    assign o_list_empty = r_o_empty;
    assign o_found      = r_o_found;
    assign o_pool_full  = r_o_full;
endmodule

/* test/cdl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_checker
// Watches the request and result channels of the cursor linked list block,
// keeps its own copy of the list, pool and cursor, and compares every result
// with the prediction made when its request was taken.
// ----------------------------------------------------------------------------
module cdl_checker
    import cdl_pkg::*;
#(
    parameter int POOL_NODES = DEF_POOL_NODES,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cdl_in_if    i_req,
    cdl_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int SENT = POOL_NODES;

    typedef struct {
        logic [COORD_BITS-1:0] line;
        logic [COORD_BITS-1:0] col;
        logic                  out;
        logic                  empty;
        logic                  found;
        logic                  full;
    } t_list_res;

    logic [COORD_BITS-1:0] pool_line [POOL_NODES];
    logic [COORD_BITS-1:0] pool_col  [POOL_NODES];
    int                    link_nx   [POOL_NODES+1];
    int                    link_pv   [POOL_NODES+1];
    int                    free_top;
    int                    cur;
    t_list_res             res_q[$];
    int                    fails;

    assign o_fail_count = fails;
    assign o_pending    = res_q.size();

    task automatic list_reset();
        for (int i = 0; i < POOL_NODES; i++) begin
            link_nx[i]   = i + 1;
            link_pv[i]   = 0;
            pool_line[i] = '0;
            pool_col[i]  = '0;
        end
        link_nx[SENT] = SENT;
        link_pv[SENT] = SENT;
        free_top      = 0;
        cur           = SENT;
    endtask

    function automatic bit list_is_empty();
        return link_nx[SENT] == SENT;
    endfunction

    task automatic unlink_cursor();
        int n, p;
        if (cur == SENT) return;
        n          = link_nx[cur];
        p          = link_pv[cur];
        link_pv[n] = p;
        link_nx[p] = n;
        link_nx[cur] = free_top;
        free_top   = cur;
        cur        = p;
    endtask

    // returns 1 when dropped for lack of a free node
    task automatic link_new(input bit left, input logic [COORD_BITS-1:0] ln,
                            input logic [COORD_BITS-1:0] cl, output bit dropped);
        int  t, p, n;
        bit  was_empty;
        was_empty = list_is_empty();
        dropped   = 1'b0;
        if (!was_empty && cur == SENT) return;
        t = free_top;
        if (t == SENT) begin
            dropped = 1'b1;
            return;
        end
        free_top     = link_nx[t];
        pool_line[t] = ln;
        pool_col[t]  = cl;
        if (was_empty) begin
            link_nx[t] = SENT; link_pv[t] = SENT;
            link_nx[SENT] = t; link_pv[SENT] = t;
        end else if (left) begin
            p = link_pv[cur];
            link_pv[t] = p; link_nx[t] = cur;
            link_nx[p] = t; link_pv[cur] = t;
        end else begin
            n = link_nx[cur];
            link_pv[t] = cur; link_nx[t] = n;
            link_pv[n] = t; link_nx[cur] = t;
        end
        cur = t;
    endtask

    task automatic apply_request(input logic [FUNC_W-1:0] f,
                                 input logic [COORD_BITS-1:0] ln,
                                 input logic [COORD_BITS-1:0] cl,
                                 output t_list_res r);
        bit hit, drop;
        int c;
        hit  = 1'b0;
        drop = 1'b0;
        case (f)
            F_CLEAR: begin
                cur = link_pv[SENT];
                for (int k = 0; k <= POOL_NODES && cur != SENT; k++) unlink_cursor();
                cur = SENT;
            end
            F_HEAD:     cur = link_nx[SENT];
            F_END:      cur = link_pv[SENT];
            F_NEXT:     if (cur != SENT) cur = link_nx[cur];
            F_PREV:     if (cur != SENT) cur = link_pv[cur];
            F_REMOVE:   unlink_cursor();
            F_INS_LEFT: link_new(1'b1, ln, cl, drop);
            F_INS_RGHT: link_new(1'b0, ln, cl, drop);
            F_APP_HEAD: begin
                cur = link_nx[SENT];
                link_new(1'b1, ln, cl, drop);
            end
            F_APP_END: begin
                cur = link_pv[SENT];
                link_new(1'b0, ln, cl, drop);
            end
            F_SEARCH: begin
                c = link_nx[SENT];
                for (int k = 0; k < POOL_NODES && c != SENT; k++) begin
                    if (pool_line[c] == ln && pool_col[c] == cl) begin
                        hit = 1'b1;
                        break;
                    end
                    c = link_nx[c];
                end
                cur = hit ? c : SENT;
            end
            default: ;
        endcase
        r.out   = (cur == SENT);
        r.line  = r.out ? '0 : pool_line[cur];
        r.col   = r.out ? '0 : pool_col[cur];
        r.empty = list_is_empty();
        r.found = hit;
        r.full  = drop;
    endtask

    task automatic report(input string name, input logic [15:0] exp_v,
                          input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_res want, got;
        if (!i_rst_n) begin
            list_reset();
            res_q.delete();
            fails = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.line  = i_res.read_line;
                got.col   = i_res.read_col;
                got.out   = i_res.cursor_out;
                got.empty = i_res.list_empty;
                got.found = i_res.found;
                got.full  = i_res.pool_full;
                if (res_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual line %0h col %0h",
                             $time, got.line, got.col);
                    fails++;
                end else begin
                    want = res_q.pop_front();
                    report("read_line", 16'(want.line), 16'(got.line));
                    report("read_col", 16'(want.col), 16'(got.col));
                    report("cursor_out", 16'(want.out), 16'(got.out));
                    report("list_empty", 16'(want.empty), 16'(got.empty));
                    report("found", 16'(want.found), 16'(got.found));
                    report("pool_full", 16'(want.full), 16'(got.full));
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(i_req.func, i_req.pos_line, i_req.pos_col, want);
                res_q.push_back(want);
            end
        end
    end

endmodule

/* test/cursor_doubly_linked_list_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_top_tb
// Drives directed and random list requests into the cursor linked list block
// under varying handshake stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module cursor_doubly_linked_list_top_tb;
    import cdl_pkg::*;

    localparam int               POOL_NODES = DEF_POOL_NODES;
    localparam int               COORD_BITS = DEF_COORD_BITS;
    localparam logic [FUNC_W-1:0] F_SPARE_LO = 4'd12;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   rx_hold;

    cdl_in_if  #(.COORD_BITS(COORD_BITS)) req_ch ();
    cdl_out_if #(.COORD_BITS(COORD_BITS)) res_ch ();

    cursor_doubly_linked_list_top #(
        .POOL_NODES(POOL_NODES),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (req_ch),
        .o_res  (res_ch)
    );

    cdl_checker #(
        .POOL_NODES(POOL_NODES),
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid    = 1'b0;
        req_ch.func     = F_READ;
        req_ch.pos_line = '0;
        req_ch.pos_col  = '0;
        res_ch.ready    = 1'b0;
    end

    always @(negedge i_clk) begin
        if (rx_hold) res_ch.ready <= 1'b0;
        else         res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_req(input logic [FUNC_W-1:0] f, input logic [COORD_BITS-1:0] ln,
                            input logic [COORD_BITS-1:0] cl);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid    <= 1'b1;
        req_ch.func     <= f;
        req_ch.pos_line <= ln;
        req_ch.pos_col  <= cl;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // small coordinates mostly, so searches hit and duplicates show up
    function automatic logic [COORD_BITS-1:0] pick_coord();
        if ($urandom_range(9) < 7) return COORD_BITS'($urandom_range(3));
        return COORD_BITS'($urandom);
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(99);
        if (r < 1)  return F_CLEAR;
        if (r < 3)  return F_SPARE_LO + FUNC_W'($urandom_range(3));
        if (r < 8)  return F_HEAD;
        if (r < 13) return F_END;
        if (r < 21) return F_NEXT;
        if (r < 28) return F_PREV;
        if (r < 32) return F_READ;
        if (r < 42) return F_REMOVE;
        if (r < 52) return F_INS_LEFT;
        if (r < 62) return F_INS_RGHT;
        if (r < 72) return F_APP_HEAD;
        if (r < 84) return F_APP_END;
        return F_SEARCH;
    endfunction

    task automatic random_reqs(input int count);
        for (int i = 0; i < count; i++) send_req(pick_func(), pick_coord(), pick_coord());
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold     = 1'b0;
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty list: steps, read, remove and search while out
        send_req(F_READ, 8'd0, 8'd0);
        send_req(F_NEXT, 8'd0, 8'd0);
        send_req(F_PREV, 8'd0, 8'd0);
        send_req(F_REMOVE, 8'd0, 8'd0);
        send_req(F_SEARCH, 8'd255, 8'd255);
        // insert while out into an empty list takes place
        send_req(F_INS_LEFT, 8'd255, 8'd0);
        send_req(F_INS_RGHT, 8'd0, 8'd255);
        send_req(F_APP_HEAD, 8'd255, 8'd255);
        send_req(F_APP_END, 8'd0, 8'd0);
        send_req(F_HEAD, 8'd0, 8'd0);
        send_req(F_PREV, 8'd0, 8'd0);
        send_req(F_END, 8'd0, 8'd0);
        send_req(F_NEXT, 8'd0, 8'd0);
        send_req(F_SEARCH, 8'd0, 8'd255);
        send_req(F_REMOVE, 8'd0, 8'd0);
        // search miss leaves cursor out, then an insert is ignored
        send_req(F_SEARCH, 8'd7, 8'd7);
        send_req(F_INS_LEFT, 8'd1, 8'd1);
        send_req(F_INS_RGHT, 8'd1, 8'd1);
        for (int k = 0; k < 4; k++) send_req(F_SPARE_LO + FUNC_W'(k), 8'd9, 8'd9);
        send_req(F_HEAD, 8'd0, 8'd0);
        send_req(F_REMOVE, 8'd0, 8'd0);
        send_req(F_CLEAR, 8'd0, 8'd0);
        send_req(F_READ, 8'd0, 8'd0);

        tx_idle_pct = 26;
        rx_idle_pct = 48;
        random_reqs(550);

        // fill the pool past its limit while the receiver holds off
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                for (int i = 0; i < POOL_NODES + 10; i++)
                    send_req(($urandom_range(1) != 0) ? F_APP_END : F_INS_LEFT,
                             pick_coord(), pick_coord());
            end
        join
        drain();
        send_req(F_SEARCH, 8'd255, 8'd255);
        send_req(F_APP_HEAD, 8'd3, 8'd3);
        random_reqs(40);
        send_req(F_CLEAR, 8'd0, 8'd0);

        tx_idle_pct = 48;
        rx_idle_pct = 26;
        random_reqs(550);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_reqs(550);

        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) $display("All tests passed");
        else                 $display("Some tests failed");
        $finish;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
